// ===== hdl/qs_pkg.sv =====
// shared constants of the quicksort engine
package qs_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int VALUE_W       = 32;

endpackage

// ===== hdl/qs_ram.sv =====
// generic simple dual-port ram with registered read
module qs_ram #(
   parameter int WIDTH = qs_pkg::VALUE_W,
   parameter int DEPTH = qs_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/qs_sorter.sv =====
// in-place quicksort sequencer with a stack of pending index ranges
module qs_sorter #(
   parameter int DEPTH = qs_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [$clog2(DEPTH+1)-1:0]       count,
   output logic                             done,
   output logic [$clog2(DEPTH)-1:0]         mem_rd_addr,
   input  logic [qs_pkg::VALUE_W-1:0]       mem_rd_data,
   output logic                             mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]         mem_wr_addr,
   output logic [qs_pkg::VALUE_W-1:0]       mem_wr_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam int SW = IW + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_POP, S_POP_WAIT, S_PIV_WAIT, S_LOOP,
      S_SCAN_I, S_SCAN_J, S_SWAP, S_PUSH_HI, S_PUSH_LO
   } state_type;

   state_type                          state_ff;
   logic [CW-1:0]                      sp_ff;
   logic [IW-1:0]                      lo_ff, hi_ff;
   logic signed [SW-1:0]               i_ff, j_ff;
   logic signed [qs_pkg::VALUE_W-1:0]  pivot_ff, ai_ff;
   logic                               done_ff;

   logic                               stk_wr_en;
   logic [IW-1:0]                      stk_wr_addr, stk_rd_addr;
   logic [2*IW-1:0]                    stk_wr_data, stk_rd_data;

   logic [IW-1:0]                      pop_lo, pop_hi;
   logic [IW:0]                        mid_sum;
   logic signed [SW-1:0]               lo_s, hi_s, i_inc, j_dec;
   logic signed [qs_pkg::VALUE_W-1:0]  rd_val;
   logic                               i_ok, j_ok, i_le_j, scan_i_go, scan_j_go, do_swap;
   logic [CW-1:0]                      count_m1;

   qs_ram #(.WIDTH(2*IW), .DEPTH(DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign pop_lo    = stk_rd_data[2*IW-1:IW];
   assign pop_hi    = stk_rd_data[IW-1:0];
   assign mid_sum   = {1'b0, pop_lo} + {1'b0, pop_hi};
   assign lo_s      = $signed({2'b00, lo_ff});
   assign hi_s      = $signed({2'b00, hi_ff});
   assign i_inc     = i_ff + $signed(SW'(1));
   assign j_dec     = j_ff - $signed(SW'(1));
   assign rd_val    = $signed(mem_rd_data);
   assign i_ok      = i_ff <= hi_s;
   assign j_ok      = j_ff >= lo_s;
   assign i_le_j    = i_ff <= j_ff;
   assign scan_i_go = i_ok && (rd_val < pivot_ff);
   assign scan_j_go = j_ok && (rd_val > pivot_ff);
   assign do_swap   = i_le_j && i_ok && j_ok;
   assign count_m1  = count - CW'(1);
   assign done      = done_ff;

   always_comb begin
      mem_rd_addr = i_ff[IW-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = i_ff[IW-1:0];
      mem_wr_data = mem_rd_data;
      stk_wr_en   = 1'b0;
      stk_wr_addr = sp_ff[IW-1:0];
      stk_wr_data = {i_ff[IW-1:0], hi_ff};
      stk_rd_addr = IW'(sp_ff - CW'(1));
      case (state_ff)
         S_INIT: begin
            stk_wr_en   = count >= CW'(2);
            stk_wr_addr = '0;
            stk_wr_data = {{IW{1'b0}}, count_m1[IW-1:0]};
         end
         S_POP_WAIT: begin
            mem_rd_addr = mid_sum[IW:1];
         end
         S_SCAN_I: begin
            // keep one read ahead while the scan goes on
            mem_rd_addr = scan_i_go ? i_inc[IW-1:0] : j_ff[IW-1:0];
         end
         S_SCAN_J: begin
            mem_rd_addr = j_dec[IW-1:0];
            // first half of the swap: a[i] takes a[j]
            mem_wr_en   = !scan_j_go && do_swap;
         end
         S_SWAP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = j_ff[IW-1:0];
            mem_wr_data = ai_ff;
         end
         S_PUSH_HI: begin
            stk_wr_en   = i_ff < hi_s;
         end
         S_PUSH_LO: begin
            stk_wr_en   = lo_s < j_ff;
            stk_wr_data = {lo_ff, j_ff[IW-1:0]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_INIT;
               end
            end
            S_INIT: begin
               if (count < CW'(2)) begin
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  sp_ff    <= CW'(1);
                  state_ff <= S_POP;
               end
            end
            S_POP: begin
               if (sp_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  sp_ff    <= sp_ff - CW'(1);
                  state_ff <= S_POP_WAIT;
               end
            end
            S_POP_WAIT: begin
               lo_ff <= pop_lo;
               hi_ff <= pop_hi;
               i_ff  <= $signed({2'b00, pop_lo});
               j_ff  <= $signed({2'b00, pop_hi});
               if (pop_lo >= pop_hi) begin
                  state_ff <= S_POP;
               end else begin
                  state_ff <= S_PIV_WAIT;
               end
            end
            S_PIV_WAIT: begin
               pivot_ff <= rd_val;
               state_ff <= S_LOOP;
            end
            S_LOOP: begin
               state_ff <= i_le_j ? S_SCAN_I : S_PUSH_HI;
            end
            S_SCAN_I: begin
               if (scan_i_go) begin
                  i_ff <= i_inc;
               end else begin
                  ai_ff    <= rd_val;
                  state_ff <= S_SCAN_J;
               end
            end
            S_SCAN_J: begin
               if (scan_j_go) begin
                  j_ff <= j_dec;
               end else if (do_swap) begin
                  state_ff <= S_SWAP;
               end else begin
                  state_ff <= S_PUSH_HI;
               end
            end
            S_SWAP: begin
               i_ff     <= i_inc;
               j_ff     <= j_dec;
               state_ff <= S_LOOP;
            end
            S_PUSH_HI: begin
               if (i_ff < hi_s) begin
                  sp_ff <= sp_ff + CW'(1);
               end
               state_ff <= S_PUSH_LO;
            end
            S_PUSH_LO: begin
               if (lo_s < j_ff) begin
                  sp_ff <= sp_ff + CW'(1);
               end
               state_ff <= S_POP;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hdl/quicksort_engine_top.sv =====
// quicksort engine top level: load, sort and emit of one set
//
//  channel   direction  ports                                           transfer when
//  req       in         req_value, req_last                             req_valid & !req_stall
//  rsp       out        rsp_sorted_value, rsp_end_of_set, rsp_overflow  rsp_valid & !rsp_stall
//
// loading writes each accepted element into the element ram; the sort then walks that ram,
// comparing one element per cycle while it scans, with swap states and range pop and push states.
// each result is read, then captured, through the single registered read port, one at a time.
// synchronous reset clears control only; the rams need no clearing pass.
// req_stall is high from the last element until the final result is registered.
module quicksort_engine_top #(
   parameter int DEPTH = qs_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [qs_pkg::VALUE_W-1:0] req_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [qs_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic                              rsp_end_of_set,
   output logic                              rsp_overflow
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   typedef enum logic [2:0] {
      T_LOAD, T_SORT_GO, T_SORT_WAIT, T_EMIT_RD, T_EMIT_CAP
   } state_type;

   state_type                          state_ff;
   logic [CW-1:0]                      count_ff, k_ff;
   logic                               ovf_ff, out_valid_ff;
   logic signed [qs_pkg::VALUE_W-1:0]  value_ff;
   logic                               end_ff, out_ovf_ff;

   logic                               req_xfer, load_wr, out_free, is_final;
   logic                               sort_done, sort_wr_en;
   logic [IW-1:0]                      sort_rd_addr, sort_wr_addr;
   logic [qs_pkg::VALUE_W-1:0]         sort_wr_data;
   logic                               ram_wr_en;
   logic [IW-1:0]                      ram_wr_addr, ram_rd_addr;
   logic [qs_pkg::VALUE_W-1:0]         ram_wr_data, ram_rd_data;

   assign req_stall = state_ff != T_LOAD;
   assign req_xfer  = req_valid && !req_stall;
   assign load_wr   = req_xfer && (count_ff < CW'(DEPTH));
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign is_final  = k_ff == (count_ff - CW'(1));

   assign ram_wr_en   = load_wr || sort_wr_en;
   assign ram_wr_addr = load_wr ? count_ff[IW-1:0] : sort_wr_addr;
   assign ram_wr_data = load_wr ? req_value : sort_wr_data;
   assign ram_rd_addr = (state_ff == T_EMIT_RD) ? k_ff[IW-1:0] : sort_rd_addr;

   qs_ram #(.WIDTH(qs_pkg::VALUE_W), .DEPTH(DEPTH)) u_elements (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   qs_sorter #(.DEPTH(DEPTH)) u_sorter (
      .clock       (clock),
      .reset       (reset),
      .start       (state_ff == T_SORT_GO),
      .count       (count_ff),
      .done        (sort_done),
      .mem_rd_addr (sort_rd_addr),
      .mem_rd_data (ram_rd_data),
      .mem_wr_en   (sort_wr_en),
      .mem_wr_addr (sort_wr_addr),
      .mem_wr_data (sort_wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_LOAD;
         count_ff     <= '0;
         k_ff         <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            T_LOAD: begin
               if (req_xfer) begin
                  if (load_wr) begin
                     count_ff <= count_ff + CW'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_last) begin
                     state_ff <= T_SORT_GO;
                  end
               end
            end
            T_SORT_GO: begin
               state_ff <= T_SORT_WAIT;
            end
            T_SORT_WAIT: begin
               if (sort_done) begin
                  k_ff     <= '0;
                  state_ff <= T_EMIT_RD;
               end
            end
            T_EMIT_RD: begin
               if (out_free) begin
                  state_ff <= T_EMIT_CAP;
               end
            end
            T_EMIT_CAP: begin
               value_ff     <= $signed(ram_rd_data);
               end_ff       <= is_final;
               out_ovf_ff   <= ovf_ff;
               out_valid_ff <= 1'b1;
               k_ff         <= k_ff + CW'(1);
               if (is_final) begin
                  // set done: next transfer starts a new one
                  count_ff <= '0;
                  ovf_ff   <= 1'b0;
                  state_ff <= T_LOAD;
               end else begin
                  state_ff <= T_EMIT_RD;
               end
            end
            default: begin
               state_ff <= T_LOAD;
            end
         endcase
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sorted_value = value_ff;
   assign rsp_end_of_set   = end_ff;
   assign rsp_overflow     = out_ovf_ff;

endmodule

// ===== tb/tb_quicksort_engine_top.sv =====
// self-checking testbench of the quicksort engine: sets in, sorted sets out
`timescale 1ns / 100ps

module tb_quicksort_engine_top;

   localparam int VW             = qs_pkg::VALUE_W;
   localparam int DEPTH          = qs_pkg::DEPTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 400;
   localparam logic signed [VW-1:0] VALUE_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VALUE_MIN = {1'b1, {(VW-1){1'b0}}};

   typedef struct packed {
      logic signed [VW-1:0] value;
      logic                 end_of_set;
      logic                 overflow;
   } sorted_item_type;

   typedef struct packed {
      logic signed [VW-1:0] value;
      logic                 last;
      logic                 typed;
      sorted_item_type      result;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [VW-1:0] req_value;
   logic                 req_last;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [VW-1:0] rsp_sorted_value;
   logic                 rsp_end_of_set;
   logic                 rsp_overflow;

   quicksort_engine_top #(.DEPTH(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_end_of_set   (rsp_end_of_set),
      .rsp_overflow     (rsp_overflow)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // directed stimulus; single-element sets carry their result typed in
   localparam int N_ROWS = 21;
   stim_row_type stim_rows [N_ROWS] = '{
      '{VALUE_MAX, 1'b1, 1'b1, '{VALUE_MAX, 1'b1, 1'b0}},
      '{VALUE_MIN, 1'b1, 1'b1, '{VALUE_MIN, 1'b1, 1'b0}},
      '{32'sd0,    1'b1, 1'b1, '{32'sd0,    1'b1, 1'b0}},
      '{-32'sd1,   1'b1, 1'b1, '{-32'sd1,   1'b1, 1'b0}},
      '{VALUE_MAX, 1'b0, 1'b0, '0},
      '{VALUE_MIN, 1'b0, 1'b0, '0},
      '{32'sd0,    1'b0, 1'b0, '0},
      '{-32'sd1,   1'b1, 1'b0, '0},
      '{32'hAAAAAAAA, 1'b0, 1'b0, '0},
      '{32'h55555555, 1'b1, 1'b0, '0},
      '{32'sd9,    1'b0, 1'b0, '0},
      '{-32'sd9,   1'b1, 1'b0, '0},
      '{32'sd5,    1'b0, 1'b0, '0},
      '{32'sd5,    1'b0, 1'b0, '0},
      '{32'sd5,    1'b0, 1'b0, '0},
      '{32'sd5,    1'b1, 1'b0, '0},
      '{32'sd3,    1'b0, 1'b0, '0},
      '{32'sd1,    1'b0, 1'b0, '0},
      '{32'sd2,    1'b0, 1'b0, '0},
      '{-32'sd4,   1'b0, 1'b0, '0},
      '{32'sd1,    1'b1, 1'b0, '0}
   };

   // predictor state
   logic signed [VW-1:0] set_store [DEPTH];
   int                   set_count;
   bit                   set_dropped;
   sorted_item_type      pending_sorted [$];

   int  mismatch_count;
   bit  tx_eager;
   int  quiet_cycles;

   task automatic report_mismatch(input string what, input logic [VW-1:0] got,
                                  input logic [VW-1:0] want);
      $display("mismatch in %s at %0t: got %h, expected %h", what, $realtime, got, want);
      mismatch_count++;
   endtask

   // store one element; on the closing one sort the set and, if queue_results is set, queue its results
   function automatic void absorb_element(input logic signed [VW-1:0] value,
                                          input bit last, input bit queue_results);
      logic signed [VW-1:0] key;
      sorted_item_type      item;
      int                   i;
      int                   j;
      if (set_count < DEPTH) begin
         set_store[set_count] = value;
         set_count++;
      end else begin
         set_dropped = 1'b1;
      end
      if (!last)
         return;
      for (i = 1; i < set_count; i++) begin
         key = set_store[i];
         j = i - 1;
         while (j >= 0 && set_store[j] > key) begin
            set_store[j+1] = set_store[j];
            j--;
         end
         set_store[j+1] = key;
      end
      if (queue_results) begin
         for (i = 0; i < set_count; i++) begin
            item.value      = set_store[i];
            item.end_of_set = (i == set_count - 1);
            item.overflow   = set_dropped;
            pending_sorted.push_back(item);
         end
      end
      set_count   = 0;
      set_dropped = 1'b0;
   endfunction

   function automatic logic signed [VW-1:0] draw_value();
      case ($urandom_range(0, 9))
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         2, 3:    return int'($urandom_range(0, 16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   // offer one element and wait for its transfer; valid stays high afterwards
   task automatic send_item(input logic signed [VW-1:0] value, input bit last,
                            input bit typed, input sorted_item_type typed_result);
      int gap;
      gap = tx_eager ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_last  <= last;
      do
         @(posedge clock);
      while (req_stall);
      absorb_element(value, last, !typed);
      if (typed)
         pending_sorted.push_back(typed_result);
   endtask

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: check each transfer, then draw the stall before the next
   initial begin
      int              stall_cnt;
      bit              rx_eager;
      bit              long_hold_done;
      sorted_item_type want;
      rsp_stall <= 1'b0;
      stall_cnt      = 0;
      rx_eager       = 1'b0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_sorted.size() == 0) begin
               report_mismatch("unexpected result", rsp_sorted_value, '0);
            end else begin
               want = pending_sorted.pop_front();
               if (rsp_sorted_value !== want.value)
                  report_mismatch("sorted_value", rsp_sorted_value, want.value);
               if (rsp_end_of_set !== want.end_of_set)
                  report_mismatch("end_of_set", VW'(rsp_end_of_set), VW'(want.end_of_set));
               if (rsp_overflow !== want.overflow)
                  report_mismatch("overflow", VW'(rsp_overflow), VW'(want.overflow));
            end
            if ($urandom_range(0, 19) == 0)
               rx_eager = !rx_eager;
            stall_cnt = rx_eager ? 0 : $urandom_range(0, 13);
            // hold off once mid-way through a big set so the input backs up
            if (!long_hold_done && pending_sorted.size() >= 40) begin
               stall_cnt      = LONG_HOLD;
               long_hold_done = 1'b1;
            end
         end
         if (stall_cnt > 0) begin
            rsp_stall <= 1'b1;
            stall_cnt--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int set_no;
      int set_len;
      int rand_items;
      int k;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      req_last  <= 1'b0;
      mismatch_count = 0;
      set_count      = 0;
      set_dropped    = 1'b0;
      tx_eager       = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[r])
         send_item(stim_rows[r].value, stim_rows[r].last, stim_rows[r].typed,
                   stim_rows[r].result);

      // mostly small sets, one full set and one that overruns the store
      set_no     = 0;
      rand_items = 0;
      while (rand_items < 150) begin
         if (set_no == 1)
            set_len = DEPTH;
         else if (set_no == 3)
            set_len = DEPTH + 1 + $urandom_range(0, 3);
         else if ($urandom_range(0, 3) == 0)
            set_len = $urandom_range(13, 24);
         else
            set_len = $urandom_range(1, 12);
         tx_eager = ($urandom_range(0, 3) == 0);
         for (k = 0; k < set_len; k++)
            send_item(draw_value(), k == set_len - 1, 1'b0, '0);
         rand_items += set_len;
         set_no++;
      end
      req_valid <= 1'b0;

      while (pending_sorted.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
